/* rtl/pes_pkg.sv */
// Package for particle_euler_step: constants, reset values, config indexes.
// No dependencies.
`default_nettype none
package pes_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam logic [15:0] FW_RESET = 16'd3277;
    localparam logic [15:0] LS_RESET = 16'd256;
    localparam logic [31:0] MS_RESET = 32'd429497;
    localparam logic [1:0] REG_FW = 2'd0;
    localparam logic [1:0] REG_LS = 2'd1;
    localparam logic [1:0] REG_MS = 2'd2;
endpackage
`default_nettype wire

/* rtl/particle_euler_step.sv */
// Particle Euler step top level: size/mass filters, position, velocity, shade.
// One shared 33x33 signed multiplier and a restoring divider. Uses pes_pkg.
//
// channel   dir  signals
// in        in   in_valid/in_ready, cpu_load, memory_use, elapsed, force_x/y/z
// out       out  out_valid/out_ready, pos_*, vel_*, size_out, mass_out, shade_out, overflow_flag
// cfg       in   cfg_we, cfg_index, cfg_data
//
// The velocity update runs three 57-step divisions by the new mass in the
// bit-serial divider, one per axis; they are skipped when the new mass is zero.
// The result is held while out_valid is high and out_ready is low.
// Reset sets config, position, velocity, size, mass, shade and overflow flag
// to their reset values; no clearing pass.
// in_ready is low from acceptance until the result is taken.
`default_nettype none
module particle_euler_step #(
    parameter int FRAC_BITS = pes_pkg::FRAC_BITS_DEF
) (
    input  wire  logic               clk,
    input  wire  logic               rst_n,
    input  wire  logic               cfg_we,
    input  wire  logic [1:0]         cfg_index,
    input  wire  logic [31:0]        cfg_data,
    input  wire  logic               in_valid,
    output logic                     in_ready,
    input  wire  logic [15:0]        cpu_load,
    input  wire  logic [31:0]        memory_use,
    input  wire  logic [23:0]        elapsed,
    input  wire  logic signed [31:0] force_x,
    input  wire  logic signed [31:0] force_y,
    input  wire  logic signed [31:0] force_z,
    output logic                     out_valid,
    input  wire  logic               out_ready,
    output logic signed [31:0]       pos_x,
    output logic signed [31:0]       pos_y,
    output logic signed [31:0]       pos_z,
    output logic signed [31:0]       vel_x,
    output logic signed [31:0]       vel_y,
    output logic signed [31:0]       vel_z,
    output logic [23:0]              size_out,
    output logic [31:0]              mass_out,
    output logic [16:0]              shade_out,
    output logic                     overflow_flag
);
    localparam logic [23:0] SIZE_RST = 24'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [31:0] MASS_RST = 32'(64'd1 << FRAC_BITS);
    localparam int DW = 57;
    localparam logic signed [63:0] S_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S_MIN = -64'sd2147483648;

    typedef enum logic [4:0] {
        S_IDLE, S_SZ1, S_SZ2, S_SZ3, S_MS1, S_MS2, S_MS3, S_MS4,
        S_POS, S_VMUL, S_DIV, S_VADD, S_SHD, S_SHD2, S_OUT
    } state_t;

    state_t state_reg;
    logic [15:0] fw_reg, ls_reg;
    logic [31:0] ms_reg;
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] frc_reg [3];
    logic [23:0] size_reg;
    logic [31:0] mass_reg;
    logic [16:0] shade_reg;
    logic [15:0] cpu_reg;
    logic [31:0] mem_reg;
    logic [23:0] dt_reg;
    logic ovf_reg;
    logic [1:0] idx_reg;
    logic [63:0] acc_reg;
    logic [63:0] t_reg;
    // divider
    logic [DW-1:0] quo_reg;
    logic [31:0] rem_reg;
    logic neg_reg;
    logic [5:0] cnt_reg;

    // shared multiplier
    logic signed [32:0] ma, mb;
    logic signed [65:0] mp;
    assign mp = ma * mb;

    logic [16:0] keep;
    assign keep = 17'd65536 - {1'b0, fw_reg};

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            S_SZ1: begin ma = {9'd0, size_reg}; mb = {16'd0, keep}; end
            S_SZ2: begin ma = {17'd0, cpu_reg}; mb = {17'd0, ls_reg}; end
            S_SZ3: begin ma = {1'b0, t_reg[31:0]}; mb = {17'd0, fw_reg}; end
            S_MS1: begin ma = {1'b0, mass_reg}; mb = {16'd0, keep}; end
            S_MS2: begin ma = {1'b0, mem_reg}; mb = {1'b0, ms_reg}; end
            S_MS3: begin ma = {1'b0, t_reg[63:32]}; mb = {17'd0, fw_reg}; end
            S_MS4: begin ma = {1'b0, t_reg[31:0]}; mb = {17'd0, fw_reg}; end
            S_POS: begin ma = {vel_reg[idx_reg][31], vel_reg[idx_reg]}; mb = {9'd0, dt_reg}; end
            S_VMUL: begin ma = {frc_reg[idx_reg][31], frc_reg[idx_reg]}; mb = {9'd0, dt_reg}; end
            S_SHD: begin ma = {16'd0, 17'd65536 - shade_reg}; mb = {9'd0, dt_reg}; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    logic signed [63:0] prod;
    assign prod = 64'(mp);

    // floor shift of signed product and saturating add
    logic signed [63:0] fsh, psum, vsum, sdelta;
    logic [32:0] rtrial;
    assign fsh = prod >>> FRAC_BITS;
    assign psum = 64'(pos_reg[idx_reg]) + fsh;
    assign sdelta = neg_reg ? -$signed(64'(quo_reg)) : $signed(64'(quo_reg));
    assign vsum = 64'(vel_reg[idx_reg]) + sdelta;
    assign rtrial = {rem_reg, acc_reg[DW-1]} - {1'b0, mass_reg};

    logic [63:0] mprod;
    assign mprod = 64'(mp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fw_reg <= pes_pkg::FW_RESET;
            ls_reg <= pes_pkg::LS_RESET;
            ms_reg <= pes_pkg::MS_RESET;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
            size_reg <= SIZE_RST;
            mass_reg <= MASS_RST;
            shade_reg <= '0;
            ovf_reg <= 1'b0;
            idx_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pes_pkg::REG_FW: fw_reg <= cfg_data[15:0];
                    pes_pkg::REG_LS: ls_reg <= cfg_data[15:0];
                    pes_pkg::REG_MS: ms_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        cpu_reg <= cpu_load;
                        mem_reg <= memory_use;
                        dt_reg <= elapsed;
                        frc_reg[0] <= force_x;
                        frc_reg[1] <= force_y;
                        frc_reg[2] <= force_z;
                        ovf_reg <= 1'b0;
                        state_reg <= S_SZ1;
                    end
                S_SZ1: begin acc_reg <= mprod >> 16; state_reg <= S_SZ2; end
                S_SZ2: begin t_reg <= mprod; state_reg <= S_SZ3; end
                S_SZ3:
                begin
                    if (acc_reg + (mprod >> (32 - FRAC_BITS)) > 64'hFFFFFF)
                    begin
                        size_reg <= '1;
                        ovf_reg <= 1'b1;
                    end
                    else
                        size_reg <= 24'(acc_reg + (mprod >> (32 - FRAC_BITS)));
                    state_reg <= S_MS1;
                end
                S_MS1: begin acc_reg <= mprod >> 16; state_reg <= S_MS2; end
                S_MS2: begin t_reg <= mprod >> 16; state_reg <= S_MS3; end
                S_MS3: begin t_reg[63:32] <= mprod[31:0]; state_reg <= S_MS4; end
                S_MS4:
                begin
                    // (hi*p << 32 + lo*p) >> (32-F)
                    t_reg <= (({t_reg[63:32], 32'd0} + mprod) >> (32 - FRAC_BITS))
                             + acc_reg;
                    state_reg <= S_SHD2;
                    idx_reg <= '0;
                end
                S_SHD2:
                begin
                    if (t_reg > 64'hFFFFFFFF)
                    begin
                        mass_reg <= '1;
                        ovf_reg <= 1'b1;
                    end
                    else
                        mass_reg <= t_reg[31:0];
                    state_reg <= S_POS;
                end
                S_POS:
                begin
                    if (psum > S_MAX) pos_reg[idx_reg] <= 32'sh7FFFFFFF;
                    else if (psum < S_MIN) pos_reg[idx_reg] <= 32'sh80000000;
                    else pos_reg[idx_reg] <= psum[31:0];
                    // saturation, or zero mass on the last axis
                    if (psum > S_MAX || psum < S_MIN || (idx_reg == 2'd2 && mass_reg == '0))
                        ovf_reg <= 1'b1;
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg <= '0;
                        if (mass_reg == '0)
                            state_reg <= S_SHD;
                        else
                            state_reg <= S_VMUL;
                    end
                    else
                        idx_reg <= idx_reg + 2'd1;
                end
                S_VMUL:
                begin
                    neg_reg <= prod[63];
                    acc_reg <= prod[63] ? 64'(-prod) : 64'(prod);
                    rem_reg <= '0;
                    cnt_reg <= 6'(DW);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (!rtrial[32])
                    begin
                        rem_reg <= rtrial[31:0];
                        quo_reg <= {quo_reg[DW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[30:0], acc_reg[DW-1]};
                        quo_reg <= {quo_reg[DW-2:0], 1'b0};
                    end
                    acc_reg <= acc_reg << 1;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                        state_reg <= S_VADD;
                end
                S_VADD:
                begin
                    if (vsum > S_MAX) begin vel_reg[idx_reg] <= 32'sh7FFFFFFF; ovf_reg <= 1'b1; end
                    else if (vsum < S_MIN) begin vel_reg[idx_reg] <= 32'sh80000000; ovf_reg <= 1'b1; end
                    else vel_reg[idx_reg] <= vsum[31:0];
                    if (idx_reg == 2'd2)
                        state_reg <= S_SHD;
                    else
                    begin
                        idx_reg <= idx_reg + 2'd1;
                        state_reg <= S_VMUL;
                    end
                end
                S_SHD:
                begin
                    if (shade_reg >= 17'd65536)
                        shade_reg <= 17'd65536;
                    else if (64'(shade_reg) + (mprod >> FRAC_BITS) > 64'd65536)
                        shade_reg <= 17'd65536;
                    else
                        shade_reg <= 17'(64'(shade_reg) + (mprod >> FRAC_BITS));
                    state_reg <= S_OUT;
                end
                S_OUT:
                    if (out_ready)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign pos_x = pos_reg[0];
    assign pos_y = pos_reg[1];
    assign pos_z = pos_reg[2];
    assign vel_x = vel_reg[0];
    assign vel_y = vel_reg[1];
    assign vel_z = vel_reg[2];
    assign size_out = size_reg;
    assign mass_out = mass_reg;
    assign shade_out = shade_reg;
    assign overflow_flag = ovf_reg;

    a_shade_max: assert property (@(posedge clk) disable iff (!rst_n)
        shade_reg <= 17'd65536) else $error("shade above one");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VMUL) |=> (state_reg == S_DIV && cnt_reg == 6'(DW)))
        else $error("divider start");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(pos_x) && $stable(vel_x)))
        else $error("result changed while stalled");
    a_zero_mass: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mass_out == '0) |-> overflow_flag) else $error("zero mass unflagged");
endmodule
`default_nettype wire
